@@ sv/drb_pkg.sv @@
// ----------------------------------------------------------------------------
// Diagonal rotate package
// Shared sizes, fixed-point constants, codes and types of the diagonal
// rotation block.
// ----------------------------------------------------------------------------
`default_nettype none

package drb_pkg;

    // Frame store geometry.
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);

    // Each parity bank holds one quarter of the frame.
    localparam int BANK_AW    = (ROW_BITS - 1) + (COL_BITS - 1);
    localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / 4;

    // Item and register field widths.
    localparam int POS_BITS  = 10;
    localparam int CFG_BITS  = 10;
    localparam int CH_BITS   = 16;
    localparam int PIX_BITS  = 3 * CH_BITS;
    localparam int IDX_BITS  = 2;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    // Fixed point: step is sqrt(0.5) rounded to nearest in Q0.FRAC_BITS.
    localparam int FRAC_BITS = 16;
    localparam longint unsigned STEP_Q32 = 64'd3037000500;
    localparam longint unsigned STEP_Q   =
        (STEP_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [FRAC_BITS-1:0] STEP = STEP_Q[FRAC_BITS-1:0];

    // Source row product is signed, column product unsigned.
    localparam int R_W    = POS_BITS + FRAC_BITS + 2;
    localparam int C_W    = POS_BITS + FRAC_BITS + 1;
    localparam int UR_W   = R_W - 1 - FRAC_BITS;
    localparam int UC_W   = C_W - FRAC_BITS;
    localparam int TOP_W  = CH_BITS + FRAC_BITS;

    // Register indexes.
    localparam logic [IDX_BITS-1:0] CFG_DIAG_WIDTH = 2'd0;
    localparam logic [IDX_BITS-1:0] CFG_IN_WIDTH   = 2'd1;
    localparam logic [IDX_BITS-1:0] CFG_IN_HEIGHT  = 2'd2;

    // Item kinds.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef logic [PIX_BITS-1:0] pixel_t;

    // Source point of a request as seen by the frame store and the mixer.
    typedef struct packed {
        logic                 in_img;
        logic                 pass;
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        logic [FRAC_BITS-1:0] fr;
        logic [FRAC_BITS-1:0] fc;
    } geom_t;

endpackage

`default_nettype wire

@@ sv/drb_geom.sv @@
// ----------------------------------------------------------------------------
// Source point mapper
// Multiplies the output position by sqrt(0.5) into the source row and
// column, then checks bounds and splits off the fractions.
// ----------------------------------------------------------------------------
`default_nettype none

module drb_geom (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [drb_pkg::POS_BITS-1:0]  px_in,
    input  wire logic [drb_pkg::POS_BITS-1:0]  py_in,
    input  wire logic [drb_pkg::POS_BITS-1:0]  px_held,
    input  wire logic [drb_pkg::POS_BITS-1:0]  py_held,
    input  wire logic [drb_pkg::CFG_BITS-1:0]  diag_width,
    input  wire logic [drb_pkg::CFG_BITS-1:0]  img_w,
    input  wire logic [drb_pkg::CFG_BITS-1:0]  img_h,
    output drb_pkg::geom_t                     geom
);
    import drb_pkg::*;

    logic signed [POS_BITS:0]   dxy;
    logic        [POS_BITS:0]   sxy;
    logic        [CFG_BITS-1:0] fw;
    logic signed [R_W-1:0]      fw_term;
    logic signed [R_W-1:0]      prod_r;
    logic signed [R_W-1:0]      r_next;
    logic        [C_W-1:0]      c_next;
    logic signed [R_W-1:0]      r_reg;
    logic        [C_W-1:0]      c_reg;
    logic        [UR_W-1:0]     ur;
    logic        [UC_W-1:0]     uc;

    // Source row r = (diag_width-1) + (row-col)*step, column c = (row+col)*step.
    always_comb
    begin
        dxy     = $signed({1'b0, py_in}) - $signed({1'b0, px_in});
        sxy     = {1'b0, px_in} + {1'b0, py_in};
        fw      = diag_width - CFG_BITS'(1);
        fw_term = $signed({{(R_W - CFG_BITS - FRAC_BITS){1'b0}}, fw, {FRAC_BITS{1'b0}}});
        prod_r  = R_W'(dxy * $signed({1'b0, STEP}));
        r_next  = fw_term + prod_r;
        c_next  = C_W'(sxy) * C_W'(STEP);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            c_reg <= c_next;
        end
    end

    // Bounds and neighbour position of the registered point.
    always_comb
    begin
        ur = r_reg[R_W-2:FRAC_BITS];
        uc = c_reg[C_W-1:FRAC_BITS];
        if (diag_width == '0)
        begin
            // Rotation off: the stored pixel is taken as it is.
            geom.pass   = 1'b1;
            geom.in_img = (px_held < img_w) && (py_held < img_h);
            geom.row    = py_held[ROW_BITS-1:0];
            geom.col    = px_held[COL_BITS-1:0];
            geom.fr     = '0;
            geom.fc     = '0;
        end
        else
        begin
            // The point and its lower right neighbour must both lie inside.
            geom.pass   = 1'b0;
            geom.in_img = !r_reg[R_W-1]
                       && ((UR_W + 1)'(ur) + (UR_W + 1)'(2) <= (UR_W + 1)'(img_h))
                       && ((UC_W + 1)'(uc) + (UC_W + 1)'(2) <= (UC_W + 1)'(img_w));
            geom.row    = ur[ROW_BITS-1:0];
            geom.col    = uc[COL_BITS-1:0];
            geom.fr     = r_reg[FRAC_BITS-1:0];
            geom.fc     = c_reg[FRAC_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

@@ sv/drb_bank.sv @@
// ----------------------------------------------------------------------------
// Parity bank
// One quarter of the frame store: a single-port-write, single-port-read
// synchronous memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module drb_bank (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [drb_pkg::BANK_AW-1:0]  waddr,
    input  wire drb_pkg::pixel_t              wdata,
    input  wire logic                         re,
    input  wire logic [drb_pkg::BANK_AW-1:0]  raddr,
    output drb_pkg::pixel_t                   rdata
);
    import drb_pkg::*;

    pixel_t mem [BANK_DEPTH];
    pixel_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/drb_store.sv @@
// ----------------------------------------------------------------------------
// Frame store
// Four banks split by row and column parity, so that any 2x2 neighbourhood
// is read in a single access. Read words are routed back to their positions.
// ----------------------------------------------------------------------------
`default_nettype none

module drb_store (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [drb_pkg::POS_BITS-1:0]  wr_x,
    input  wire logic [drb_pkg::POS_BITS-1:0]  wr_y,
    input  wire drb_pkg::pixel_t               wr_pix,
    input  wire logic                          re,
    input  wire logic [drb_pkg::ROW_BITS-1:0]  rd_row,
    input  wire logic [drb_pkg::COL_BITS-1:0]  rd_col,
    output drb_pkg::pixel_t                    t0,
    output drb_pkg::pixel_t                    t1,
    output drb_pkg::pixel_t                    b0,
    output drb_pkg::pixel_t                    b1
);
    import drb_pkg::*;

    logic                wr_ok;
    logic [BANK_AW-1:0]  waddr;
    logic [ROW_BITS-2:0] row_hi [2];
    logic [COL_BITS-2:0] col_hi [2];
    logic [3:0]          bank_we;
    pixel_t              bank_rd [4];
    logic                row_par_reg;
    logic                col_par_reg;

    // Writes outside the store are dropped.
    always_comb
    begin
        wr_ok = ({1'b0, wr_x} < (POS_BITS + 1)'(MAX_WIDTH))
             && ({1'b0, wr_y} < (POS_BITS + 1)'(MAX_HEIGHT));
        waddr = {wr_y[ROW_BITS-1:1], wr_x[COL_BITS-1:1]};
    end

    // The even bank holds the next row or column when the first one is odd.
    always_comb
    begin
        row_hi[0] = rd_row[ROW_BITS-1:1] + (ROW_BITS - 1)'(rd_row[0]);
        row_hi[1] = rd_row[ROW_BITS-1:1];
        col_hi[0] = rd_col[COL_BITS-1:1] + (COL_BITS - 1)'(rd_col[0]);
        col_hi[1] = rd_col[COL_BITS-1:1];
    end

    // Bank b holds row parity b / 2 and column parity b % 2.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        assign bank_we[b] = we && wr_ok && (wr_y[0] == 1'(b / 2)) && (wr_x[0] == 1'(b % 2));

        drb_bank u_bank (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (waddr),
            .wdata (wr_pix),
            .re    (re),
            .raddr ({row_hi[b / 2], col_hi[b % 2]}),
            .rdata (bank_rd[b])
        );
    end

    // Parity of the top left neighbour, aligned with the read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            row_par_reg <= rd_row[0];
            col_par_reg <= rd_col[0];
        end
    end

    always_comb
    begin
        t0 = bank_rd[{row_par_reg, col_par_reg}];
        t1 = bank_rd[{row_par_reg, !col_par_reg}];
        b0 = bank_rd[{!row_par_reg, col_par_reg}];
        b1 = bank_rd[{!row_par_reg, !col_par_reg}];
    end

endmodule

`default_nettype wire

@@ sv/drb_mix.sv @@
// ----------------------------------------------------------------------------
// Bilinear mixer
// Two multiply stages per channel: across the columns, then across the rows.
// Each blend is written as a + (b - a) * f, which is exact and needs one
// multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module drb_mix (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire drb_pkg::pixel_t                t0,
    input  wire drb_pkg::pixel_t                t1,
    input  wire drb_pkg::pixel_t                b0,
    input  wire drb_pkg::pixel_t                b1,
    input  wire logic [drb_pkg::FRAC_BITS-1:0]  fc,
    input  wire logic [drb_pkg::FRAC_BITS-1:0]  fr,
    input  wire logic                           pass,
    output drb_pkg::pixel_t                     pix
);
    import drb_pkg::*;

    logic [FRAC_BITS-1:0] fr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fr_reg <= fr;
        end
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_chan
        logic        [CH_BITS-1:0]             a0;
        logic        [CH_BITS-1:0]             a1;
        logic        [CH_BITS-1:0]             c0;
        logic        [CH_BITS-1:0]             c1;
        logic signed [CH_BITS:0]               dtop;
        logic signed [CH_BITS:0]               dbot;
        logic signed [CH_BITS+FRAC_BITS+1:0]   sum_top;
        logic signed [CH_BITS+FRAC_BITS+1:0]   sum_bot;
        logic        [TOP_W-1:0]               top_reg;
        logic        [TOP_W-1:0]               bot_reg;
        logic signed [TOP_W:0]                 dv;
        logic signed [TOP_W+FRAC_BITS+1:0]     sum_v;

        // Column blend; in pass-through only the first word is used.
        always_comb
        begin
            a0      = t0[ch*CH_BITS +: CH_BITS];
            a1      = pass ? a0 : t1[ch*CH_BITS +: CH_BITS];
            c0      = pass ? a0 : b0[ch*CH_BITS +: CH_BITS];
            c1      = pass ? a0 : b1[ch*CH_BITS +: CH_BITS];
            dtop    = $signed({1'b0, a1}) - $signed({1'b0, a0});
            dbot    = $signed({1'b0, c1}) - $signed({1'b0, c0});
            sum_top = $signed({2'b0, a0, {FRAC_BITS{1'b0}}})
                    + (CH_BITS + FRAC_BITS + 2)'(dtop * $signed({1'b0, fc}));
            sum_bot = $signed({2'b0, c0, {FRAC_BITS{1'b0}}})
                    + (CH_BITS + FRAC_BITS + 2)'(dbot * $signed({1'b0, fc}));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                top_reg <= sum_top[TOP_W-1:0];
                bot_reg <= sum_bot[TOP_W-1:0];
            end
        end

        // Row blend, then truncate both fractions away.
        always_comb
        begin
            dv    = $signed({1'b0, bot_reg}) - $signed({1'b0, top_reg});
            sum_v = $signed({2'b0, top_reg, {FRAC_BITS{1'b0}}})
                  + (TOP_W + FRAC_BITS + 2)'(dv * $signed({1'b0, fr_reg}));
        end

        assign pix[ch*CH_BITS +: CH_BITS] = sum_v[TOP_W+FRAC_BITS-1:2*FRAC_BITS];
    end

endmodule

`default_nettype wire

@@ sv/diagonal_rotate_bilinear.sv @@
// ----------------------------------------------------------------------------
// Diagonal rotate with bilinear mixing
// Turns a diagonally sampled image upright by 45 degrees out of a frame store.
// ----------------------------------------------------------------------------
// Usage:
// Registers are written through cfg_wr_en, cfg_index and cfg_data while the
// block is idle. A word on the s_ channel is either a pixel write (s_tuser
// low), which fills the frame store and gives no result, or a request (high)
// naming an output column and row, which gives one word on the m_ channel.
// A request passes stages one to three and the output register; m_tuser says
// whether the source point lay inside the image, else the samples are zero.
// One word is taken every cycle while s_tready is high: the four neighbours
// come from four parity banks in one read, and writes use the same pipeline
// slot as reads, so a request sees every write accepted before it.
// Reset sets rotation off on a 512 by 512 image and clears the pipeline
// flags; the frame store is not cleared and reads of unwritten pixels are
// undefined.
// While the receiver stalls, the output word holds; s_tready drops only when
// a finished result is also waiting in the last stage.
// ----------------------------------------------------------------------------
`default_nettype none

module diagonal_rotate_bilinear (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Register write port.
    input  wire logic                           cfg_wr_en,
    input  wire logic [drb_pkg::IDX_BITS-1:0]   cfg_index,
    input  wire logic [drb_pkg::CFG_BITS-1:0]   cfg_data,
    // Input stream.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // pos_x[9:0], pos_y[19:10], red_in[35:20], green_in[51:36],
    // blue_in[67:52], zero fill [71:68]
    input  wire logic [drb_pkg::S_TDATA_W-1:0]  s_tdata,
    // op
    input  wire logic                           s_tuser,
    // Output stream.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // red_out[15:0], green_out[31:16], blue_out[47:32]
    output logic [drb_pkg::M_TDATA_W-1:0]       m_tdata,
    // inside_res
    output logic                                m_tuser
);
    import drb_pkg::*;

    logic [CFG_BITS-1:0]  diag_width_reg;
    logic [CFG_BITS-1:0]  in_width_reg;
    logic [CFG_BITS-1:0]  in_height_reg;
    logic [CFG_BITS-1:0]  img_w;
    logic [CFG_BITS-1:0]  img_h;

    logic                 adv;
    logic                 p1_valid_reg;
    logic                 p1_op_reg;
    logic [POS_BITS-1:0]  p1_x_reg;
    logic [POS_BITS-1:0]  p1_y_reg;
    pixel_t               p1_pix_reg;
    geom_t                geom;

    logic                 p2_valid_reg;
    logic                 p2_inside_reg;
    logic                 p2_pass_reg;
    logic [FRAC_BITS-1:0] p2_fr_reg;
    logic [FRAC_BITS-1:0] p2_fc_reg;

    logic                 p3_valid_reg;
    logic                 p3_inside_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    pixel_t               out_pix_reg;
    logic                 out_inside_reg;

    logic                 store_we;
    logic                 store_re;
    pixel_t               nb_t0;
    pixel_t               nb_t1;
    pixel_t               nb_b0;
    pixel_t               nb_b1;
    pixel_t               mix_pix;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_width_reg <= '0;
            in_width_reg   <= CFG_BITS'(512);
            in_height_reg  <= CFG_BITS'(512);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DIAG_WIDTH: diag_width_reg <= cfg_data;
                CFG_IN_WIDTH:   in_width_reg   <= cfg_data;
                CFG_IN_HEIGHT:  in_height_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Image size in use, limited to the store.
    always_comb
    begin
        img_w = (in_width_reg > CFG_BITS'(MAX_WIDTH)) ? CFG_BITS'(MAX_WIDTH) : in_width_reg;
        img_h = (in_height_reg > CFG_BITS'(MAX_HEIGHT)) ? CFG_BITS'(MAX_HEIGHT)
                                                        : in_height_reg;
    end

    // The pipeline moves unless a result in the last stage finds the output full.
    assign adv      = !(p3_valid_reg && out_valid_reg && !m_tready);
    assign s_tready = adv;

    // First stage: the accepted word and its source point products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p1_op_reg    <= OP_WRITE;
        end
        else if (adv)
        begin
            p1_valid_reg <= s_tvalid;
            p1_op_reg    <= s_tuser;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s_tvalid)
        begin
            p1_x_reg   <= s_tdata[9:0];
            p1_y_reg   <= s_tdata[19:10];
            p1_pix_reg <= s_tdata[67:20];
        end
    end

    drb_geom u_geom (
        .clk        (clk),
        .en         (adv && s_tvalid),
        .px_in      (s_tdata[9:0]),
        .py_in      (s_tdata[19:10]),
        .px_held    (p1_x_reg),
        .py_held    (p1_y_reg),
        .diag_width (diag_width_reg),
        .img_w      (img_w),
        .img_h      (img_h),
        .geom       (geom)
    );

    // Store access: writes and reads share this one slot, keeping their order.
    assign store_we = adv && p1_valid_reg && (p1_op_reg == OP_WRITE);
    assign store_re = adv && p1_valid_reg && (p1_op_reg == OP_READ) && geom.in_img;

    drb_store u_store (
        .clk    (clk),
        .we     (store_we),
        .wr_x   (p1_x_reg),
        .wr_y   (p1_y_reg),
        .wr_pix (p1_pix_reg),
        .re     (store_re),
        .rd_row (geom.row),
        .rd_col (geom.col),
        .t0     (nb_t0),
        .t1     (nb_t1),
        .b0     (nb_b0),
        .b1     (nb_b1)
    );

    // Second stage: requests only, alongside the read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg  <= 1'b0;
            p2_inside_reg <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p3_inside_reg <= 1'b0;
        end
        else if (adv)
        begin
            p2_valid_reg  <= p1_valid_reg && (p1_op_reg == OP_READ);
            p2_inside_reg <= geom.in_img;
            p3_valid_reg  <= p2_valid_reg;
            p3_inside_reg <= p2_inside_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_pass_reg <= geom.pass;
            p2_fr_reg   <= geom.fr;
            p2_fc_reg   <= geom.fc;
        end
    end

    drb_mix u_mix (
        .clk  (clk),
        .en   (adv),
        .t0   (nb_t0),
        .t1   (nb_t1),
        .b0   (nb_b0),
        .b1   (nb_b1),
        .fc   (p2_fc_reg),
        .fr   (p2_fr_reg),
        .pass (p2_pass_reg),
        .pix  (mix_pix)
    );

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv && p3_valid_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && p3_valid_reg)
        begin
            out_pix_reg    <= p3_inside_reg ? mix_pix : '0;
            out_inside_reg <= p3_inside_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tuser  = out_inside_reg;

    // A request leaving the first stage always reaches the second.
    a_req_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && (p1_op_reg == OP_READ) && adv) |=> p2_valid_reg)
        else $error("request lost between first and second stage");

    // A finished result blocked by a full output stays put.
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        (p3_valid_reg && out_valid_reg && !m_tready) |=> (p3_valid_reg && out_valid_reg))
        else $error("result in last stage dropped during stall");

    // The store slot carries either a write or a read, never both.
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({store_we, store_re}))
        else $error("store written and read in one cycle");

    // A point outside the image gives zero samples.
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_inside_reg) |-> (out_pix_reg == '0))
        else $error("non-zero samples for a point outside the image");

endmodule

`default_nettype wire

@@ bench/tb_diagonal_rotate_bilinear.sv @@
// ----------------------------------------------------------------------------
// Diagonal rotate bilinear testbench
// Drives pixel writes and output-pixel requests into the rotation block under
// several register settings, predicts every output word from a mirror of the
// frame store and compares each field of each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_diagonal_rotate_bilinear;

    import drb_pkg::*;

    localparam int      STORE_DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    // sqrt(0.5) rounded to nearest in Q0.16.
    localparam longint  STEP_Q16       = 46341;
    localparam longint  FRAC_ONE       = 65536;
    localparam int      IDLE_PCT       = 37;
    localparam int      DRAIN_CYCLES   = 8;
    localparam int      HOLD_CYCLES    = 80;
    localparam int      WATCHDOG_LIMIT = 4000;
    // Register index that selects no register.
    localparam logic [IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    // Source point of one request.
    typedef struct packed {
        logic        in_frame;
        logic        pass;
        logic [9:0]  ur;
        logic [9:0]  uc;
        logic [15:0] fr;
        logic [15:0] fc;
    } src_point_t;

    // One expected output word.
    typedef struct packed {
        logic        in_frame;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } out_pixel_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [IDX_BITS-1:0]  cfg_index;
    logic [CFG_BITS-1:0]  cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    // pos_x[9:0], pos_y[19:10], red_in[35:20], green_in[51:36],
    // blue_in[67:52], zero fill [71:68]
    logic [S_TDATA_W-1:0] s_tdata;
    // op
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // red_out[15:0], green_out[31:16], blue_out[47:32]
    logic [M_TDATA_W-1:0] m_tdata;
    // inside_res
    logic                 m_tuser;

    // Mirror of the frame store and of the registers.
    bit   [47:0] mirror_store  [STORE_DEPTH];
    bit          pixel_written [STORE_DEPTH];
    logic [9:0]  cur_diag;
    logic [9:0]  cur_width;
    logic [9:0]  cur_height;

    out_pixel_t  expected_pixels [$];
    out_pixel_t  oldest_pixel;

    bit          idle_on      = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned words_sent     = 0;
    int unsigned requests_sent  = 0;
    int unsigned pixels_checked = 0;
    int unsigned zero_pixels    = 0;
    int unsigned settings_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    diagonal_rotate_bilinear u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Maps an output position to its source point under the current registers.
    function automatic src_point_t source_point(input logic [9:0] px, input logic [9:0] py);
        src_point_t pt;
        longint     w;
        longint     h;
        longint     r;
        longint     c;
        pt = '0;
        w  = (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
        h  = (cur_height > MAX_HEIGHT) ? MAX_HEIGHT : cur_height;
        if (cur_diag == 0)
        begin
            pt.pass     = 1'b1;
            pt.in_frame = (px < w) && (py < h);
            pt.ur       = py;
            pt.uc       = px;
            return pt;
        end
        r = (longint'(cur_diag) - 1) * FRAC_ONE + (longint'(py) - longint'(px)) * STEP_Q16;
        c = (longint'(py) + longint'(px)) * STEP_Q16;
        if (r < 0 || w < 2 || h < 2)
            return pt;
        if ((r >>> FRAC_BITS) > h - 2 || (c >>> FRAC_BITS) > w - 2)
            return pt;
        pt.in_frame = 1'b1;
        pt.ur       = 10'(r >>> FRAC_BITS);
        pt.uc       = 10'(c >>> FRAC_BITS);
        pt.fr       = 16'(r);
        pt.fc       = 16'(c);
        return pt;
    endfunction

    // Output pixel of a request: passthrough or four neighbours mixed and truncated.
    function automatic out_pixel_t rotate_pixel(input logic [9:0] px, input logic [9:0] py);
        src_point_t      pt;
        out_pixel_t      res;
        int              at;
        longint unsigned wc0, wc1, wr0, wr1, top, bot;
        logic [47:0]     p00, p01, p10, p11, mixed;
        pt  = source_point(px, py);
        res = '0;
        if (!pt.in_frame)
            return res;
        res.in_frame = 1'b1;
        at  = int'(pt.ur) * MAX_WIDTH + int'(pt.uc);
        p00 = mirror_store[at];
        if (pt.pass)
            mixed = p00;
        else
        begin
            p01 = mirror_store[at + 1];
            p10 = mirror_store[at + MAX_WIDTH];
            p11 = mirror_store[at + MAX_WIDTH + 1];
            wc1 = pt.fc;
            wc0 = FRAC_ONE - wc1;
            wr1 = pt.fr;
            wr0 = FRAC_ONE - wr1;
            for (int ch = 0; ch < 3; ch++)
            begin
                top = p00[ch*16 +: 16] * wc0 + p01[ch*16 +: 16] * wc1;
                bot = p10[ch*16 +: 16] * wc0 + p11[ch*16 +: 16] * wc1;
                mixed[ch*16 +: 16] = 16'((top * wr0 + bot * wr1) >> (2 * FRAC_BITS));
            end
        end
        res.red   = mixed[15:0];
        res.green = mixed[31:16];
        res.blue  = mixed[47:32];
        return res;
    endfunction

    // Random sample with the extremes weighted up.
    function automatic logic [47:0] random_pixel();
        logic [47:0] pix;
        for (int ch = 0; ch < 3; ch++)
            case ($urandom_range(0, 7))
                0:       pix[ch*16 +: 16] = 16'h0000;
                1:       pix[ch*16 +: 16] = 16'hFFFF;
                default: pix[ch*16 +: 16] = 16'($urandom());
            endcase
        return pix;
    endfunction

    function automatic logic [9:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return 10'($urandom_range(0, 1));
            1:       return 10'd512;
            2:       return 10'd1023;
            3:       return 10'($urandom_range(2, 512));
            default: return 10'($urandom_range(2, 24));
        endcase
    endfunction

    function automatic logic [9:0] rand_diag(input logic [9:0] height);
        int lim;
        lim = (height > MAX_HEIGHT) ? MAX_HEIGHT : height;
        case ($urandom_range(0, 7))
            0:       return 10'd0;
            1:       return 10'd1;
            2:       return 10'($urandom_range(513, 1023));
            default: return 10'($urandom_range(1, lim + 1));
        endcase
    endfunction

    // Looks for an output position whose source point lies inside the image.
    function automatic void pick_target(output logic [9:0] px, output logic [9:0] py);
        int         span;
        src_point_t pt;
        span = (cur_width > cur_height) ? cur_width : cur_height;
        if (span > MAX_WIDTH)
            span = MAX_WIDTH;
        span = span + cur_diag;
        if (span > 1023)
            span = 1023;
        if (span < 3)
            span = 3;
        for (int k = 0; k < 64; k++)
        begin
            px = 10'($urandom_range(0, span));
            py = 10'($urandom_range(0, span));
            pt = source_point(px, py);
            if (pt.in_frame)
                return;
        end
    endfunction

    // Offers one word at a falling edge and returns at the falling edge after
    // it has been taken. The valid stays high so that words can follow back
    // to back.
    task automatic drive_word(input logic op, input logic [9:0] px, input logic [9:0] py,
                              input logic [47:0] rgb);
        if (idle_on)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                s_tvalid = 1'b0;
                @(negedge clk);
            end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {4'b0000, rgb, py, px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (op == OP_WRITE)
        begin
            // Writes past the end of the store are dropped.
            if (px < MAX_WIDTH && py < MAX_HEIGHT)
            begin
                mirror_store[{py[8:0], px[8:0]}]  = rgb;
                pixel_written[{py[8:0], px[8:0]}] = 1'b1;
            end
        end
        else
        begin
            expected_pixels.push_back(rotate_pixel(px, py));
            requests_sent++;
        end
        @(negedge clk);
    endtask

    // Requests one output pixel, writing any neighbour that has never been
    // written first so that no undefined store entry is ever read.
    task automatic request_pixel(input logic [9:0] px, input logic [9:0] py);
        src_point_t pt;
        logic [8:0] row;
        logic [8:0] col;
        pt = source_point(px, py);
        if (pt.in_frame)
            for (int k = 0; k < 4; k++)
            begin
                row = pt.ur[8:0] + 9'(k >> 1);
                col = pt.uc[8:0] + 9'(k & 1);
                if (!pixel_written[{row, col}])
                    drive_word(OP_WRITE, {1'b0, col}, {1'b0, row}, random_pixel());
            end
        drive_word(OP_READ, px, py, random_pixel());
    endtask

    // Drops the valid and waits until every result is in and the pipeline is empty.
    task automatic settle();
        s_tvalid = 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic set_register(input logic [IDX_BITS-1:0] idx, input logic [9:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_DIAG_WIDTH: cur_diag   = value;
            CFG_IN_WIDTH:   cur_width  = value;
            CFG_IN_HEIGHT:  cur_height = value;
            default:        ;
        endcase
    endtask

    task automatic configure(input logic [9:0] diag, input logic [9:0] width,
                             input logic [9:0] height);
        settle();
        set_register(CFG_DIAG_WIDTH, diag);
        set_register(CFG_IN_WIDTH, width);
        set_register(CFG_IN_HEIGHT, height);
        settings_count++;
    endtask

    // One random word: mostly requests that land inside the image, the rest
    // stray requests, overwrites and writes anywhere in the position range.
    task automatic random_item();
        logic [9:0]  px;
        logic [9:0]  py;
        int unsigned lim_w;
        int unsigned lim_h;
        int          sel;
        lim_w = (cur_width > MAX_WIDTH) ? MAX_WIDTH : ((cur_width < 2) ? 2 : cur_width);
        lim_h = (cur_height > MAX_HEIGHT) ? MAX_HEIGHT : ((cur_height < 2) ? 2 : cur_height);
        sel   = $urandom_range(0, 99);
        if (sel < 60)
        begin
            pick_target(px, py);
            request_pixel(px, py);
        end
        else if (sel < 72)
            request_pixel(10'($urandom()), 10'($urandom()));
        else if (sel < 90)
            drive_word(OP_WRITE, 10'($urandom_range(0, lim_w - 1)),
                       10'($urandom_range(0, lim_h - 1)), random_pixel());
        else
            drive_word(OP_WRITE, 10'($urandom()), 10'($urandom()), random_pixel());
    endtask

    // Reset values: rotation off, full-size image, store read back unchanged.
    task automatic test_passthrough();
        drive_word(OP_WRITE, 10'd0, 10'd0, {3{16'hFFFF}});
        drive_word(OP_WRITE, 10'd511, 10'd511, 48'h0);
        drive_word(OP_WRITE, 10'd511, 10'd0, random_pixel());
        drive_word(OP_WRITE, 10'd0, 10'd511, random_pixel());
        // These lie past the store and must not alias onto row or column zero.
        drive_word(OP_WRITE, 10'd512, 10'd0, 48'h1234_0000_5678);
        drive_word(OP_WRITE, 10'd0, 10'd512, 48'h0000_9ABC_0000);
        drive_word(OP_WRITE, 10'd1023, 10'd1023, random_pixel());
        request_pixel(10'd0, 10'd0);
        request_pixel(10'd511, 10'd511);
        request_pixel(10'd511, 10'd0);
        request_pixel(10'd512, 10'd3);
        request_pixel(10'd1023, 10'd1023);
    endtask

    // Small image: exact samples, full-scale mixing, and points above the
    // top, past the lower edge and far beyond the output frame.
    task automatic test_rotation_cases();
        logic [47:0] pix;
        configure(10'd2, 10'd3, 10'd3);
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++)
            begin
                if (y == 2)
                    pix = random_pixel();
                else if (y == 1 && x == 2)
                    pix = 48'h0;
                else
                    pix = {3{16'hFFFF}};
                drive_word(OP_WRITE, 10'(x), 10'(y), pix);
            end
        request_pixel(10'd0, 10'd0);
        request_pixel(10'd1, 10'd0);
        request_pixel(10'd0, 10'd1);
        request_pixel(10'd1, 10'd1);
        request_pixel(10'd3, 10'd0);
        request_pixel(10'd0, 10'd3);
        request_pixel(10'd1023, 10'd1023);
    endtask

    // Sizes over the store limit, sizes below two, an oversized diagonal and
    // a write to an index that selects no register.
    task automatic test_size_limits();
        configure(10'd0, 10'd1023, 10'd1023);
        request_pixel(10'd511, 10'd511);
        request_pixel(10'd0, 10'd512);
        configure(10'd2, 10'd1, 10'd3);
        request_pixel(10'd0, 10'd0);
        configure(10'd2, 10'd3, 10'd0);
        request_pixel(10'd0, 10'd0);
        configure(10'd1023, 10'd3, 10'd3);
        request_pixel(10'd0, 10'd0);
        configure(10'd2, 10'd3, 10'd3);
        set_register(CFG_UNUSED, 10'h3FF);
        request_pixel(10'd1, 10'd1);
    endtask

    task automatic test_random_phases();
        logic [9:0]  dw;
        logic [9:0]  w;
        logic [9:0]  h;
        int unsigned stop_at;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    dw = 10'd512;
                    w  = 10'd512;
                    h  = 10'd512;
                end
                1:
                begin
                    dw = 10'd1;
                    w  = 10'd2;
                    h  = 10'd2;
                end
                2:
                begin
                    dw = 10'd0;
                    w  = rand_size();
                    h  = rand_size();
                end
                default:
                begin
                    w  = rand_size();
                    h  = rand_size();
                    dw = rand_diag(h);
                end
            endcase
            configure(dw, w, h);
            stop_at = words_sent + 120;
            while (words_sent < stop_at)
                random_item();
        end
    endtask

    // A long run with neither side idling.
    task automatic test_streaming();
        int unsigned stop_at;
        idle_on = 1'b0;
        configure(10'($urandom_range(1, 12)), 10'($urandom_range(8, 16)),
                  10'($urandom_range(8, 16)));
        stop_at = words_sent + 220;
        while (words_sent < stop_at)
            random_item();
        settle();
        idle_on = 1'b1;
    endtask

    // The receiver holds off while requests keep coming, so the block fills
    // and must stall its input; the points are primed beforehand.
    task automatic test_backpressure();
        logic [9:0] col_list [24];
        logic [9:0] row_list [24];
        configure(10'd6, 10'd16, 10'd16);
        for (int k = 0; k < 24; k++)
        begin
            pick_target(col_list[k], row_list[k]);
            request_pixel(col_list[k], row_list[k]);
        end
        settle();
        idle_on      = 1'b0;
        hold_request = 1'b1;
        for (int k = 0; k < 24; k++)
            request_pixel(col_list[k], row_list[k]);
        settle();
        idle_on = 1'b1;
    endtask

    // Receiver: random stalls, or one long hold when asked for.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else if (idle_on)
                m_tready = ($urandom_range(0, 99) >= IDLE_PCT);
            else
                m_tready = 1'b1;
        end
    end

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Each result word is checked against the oldest expected pixel.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result word, expected none, actual %h / %b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                oldest_pixel = expected_pixels.pop_front();
                compare_field("red_out", oldest_pixel.red, m_tdata[15:0]);
                compare_field("green_out", oldest_pixel.green, m_tdata[31:16]);
                compare_field("blue_out", oldest_pixel.blue, m_tdata[47:32]);
                compare_field("inside_res", {15'b0, oldest_pixel.in_frame}, {15'b0, m_tuser});
                pixels_checked++;
                if (!oldest_pixel.in_frame)
                    zero_pixels++;
            end
        end
    end

    // Watchdog on cycles in which no word moves on any port.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_pixels.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_DIAG_WIDTH;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_WRITE;
        cur_diag   = 10'd0;
        cur_width  = 10'd512;
        cur_height = 10'd512;
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_passthrough();
        test_rotation_cases();
        test_size_limits();
        test_random_phases();
        test_streaming();
        test_backpressure();
        settle();

        $display("Sent %0d words (%0d pixel requests) under %0d register settings.",
                 words_sent, requests_sent, settings_count);
        $display("Checked %0d output pixels, %0d of them outside the source image.",
                 pixels_checked, zero_pixels);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
